>>> rtl/core/dcmt_pkg.sv
// Package for the dual 8-bit compare-match timer core.
// Holds the operation and register codes, the bit positions of the control
// registers and the prescaler divide table. No dependencies.
package dcmt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_IDLE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_TCR   = 3'd0,
    REG_TCSR  = 3'd1,
    REG_TCORA = 3'd2,
    REG_TCORB = 3'd3,
    REG_TCNT  = 3'd4,
    REG_TCCR  = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    CSS_PIN       = 2'd0,
    CSS_PRESCALER = 2'd1,
    CSS_RESERVED  = 2'd2,
    CSS_CASCADE   = 2'd3
  } css_e;

  typedef enum logic [1:0] {
    CCLR_NONE    = 2'd0,
    CCLR_MATCH_A = 2'd1,
    CCLR_MATCH_B = 2'd2,
    CCLR_EXT     = 2'd3
  } cclr_e;

  localparam int unsigned PscW = 13;
  localparam int unsigned DivW = 14;

  localparam int unsigned TcrOvie  = 5;
  localparam int unsigned TcrCmiea = 6;
  localparam int unsigned TcrCmieb = 7;

  localparam logic [7:0] TcrReadMask   = 8'hf8;
  localparam logic [7:0] Tcsr0ReadMask = 8'h3f;
  localparam logic [7:0] Tcsr1ReadMask = 8'h0f;
  localparam logic [7:0] Tcsr1ReadSet  = 8'h10;
  localparam logic [7:0] TccrReadMask  = 8'h9f;
  localparam logic [7:0] Tcsr1Reset    = 8'h10;
  localparam logic [7:0] CompareReset  = 8'hff;

  // Divide ratio for a clock select code; zero means the prescaler is stopped.
  function automatic logic [DivW-1:0] divide_ratio(input logic [2:0] cks);
    logic [DivW-1:0] d;
    case (cks)
      3'd0:    d = 14'd0;
      3'd1:    d = 14'd1;
      3'd2:    d = 14'd2;
      3'd3:    d = 14'd8;
      3'd4:    d = 14'd32;
      3'd5:    d = 14'd64;
      3'd6:    d = 14'd1024;
      default: d = 14'd8192;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/dual_8bit_compare_match_timer_core.sv
// Top level of the dual 8-bit compare-match timer with 16-bit cascade mode.
// Holds all timer registers, the per-word update logic and the result register.
// Depends on dcmt_pkg.
//
//   channel | handshake                | payload
//   --------+--------------------------+---------------------------------------
//   in      | in_valid_i / in_ready_o  | op_i, addr_i, word_access_i,
//           |                          | write_data_i
//   out     | out_valid_o / out_ready_i| read_data_o, match_a_pulse_o,
//           |                          | match_b_pulse_o, overflow_pulse_o,
//           |                          | access_error_o
//
// Each input word is processed in the cycle it is accepted, and its result
// word appears in the result register on the next cycle.
// One word is accepted in every cycle while the result register is empty or
// being drained, so the sustained rate is one word per cycle.
// Reset sets all timer registers to their documented values at once.
// A stalled output holds its result and blocks input only while it is full.
module dual_8bit_compare_match_timer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  addr_i,
  input  logic        word_access_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic [1:0]  match_a_pulse_o,
  output logic [1:0]  match_b_pulse_o,
  output logic [1:0]  overflow_pulse_o,
  output logic        access_error_o
);
  import dcmt_pkg::*;

  logic [1:0][7:0]      cnt_q, cnt_d;
  logic [1:0][7:0]      cora_q, cora_d;
  logic [1:0][7:0]      corb_q, corb_d;
  logic [1:0][7:0]      tcr_q, tcr_d;
  logic [1:0][7:0]      tcsr_q, tcsr_d;
  logic [1:0][7:0]      tccr_q, tccr_d;
  logic [1:0][PscW-1:0] psc_q, psc_d;

  logic        out_valid_q;
  logic [15:0] rd_q, rd_d;
  logic [1:0]  pa_q, pa_d, pb_q, pb_d, po_q, po_d;
  logic        err_q, err_d;

  logic        accept;
  op_e         op;
  reg_e        rsel;
  logic        ch;
  logic        is_tick, is_acc, bad;
  css_e        css0, css1;
  cclr_e       cclr0, cclr1, cclr16;
  logic        mode16;
  logic [1:0]  run;
  logic [1:0]  fire;
  logic [1:0][DivW-1:0] div;
  logic [1:0][DivW-1:0] nxt;
  logic [7:0]  v0, v1;
  logic        ma0, mb0, ov0, ma1, mb1, ov1;
  logic [15:0] v16;
  logic        ma16, mb16, ov16;
  logic        inc0, inc1, inc16;
  logic [7:0]  rbyte;
  logic [7:0]  rmask;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign op      = op_e'(op_i);
  assign rsel    = reg_e'(addr_i[3:1]);
  assign ch      = addr_i[0];
  assign is_tick = (op == OP_TICK);
  assign is_acc  = (op == OP_READ) || (op == OP_WRITE);
  assign bad     = (word_access_i && (ch || (addr_i[3:1] < 3'd2))) || (addr_i[3:1] >= 3'd6);

  assign css0   = css_e'(tccr_q[0][4:3]);
  assign css1   = css_e'(tccr_q[1][4:3]);
  assign cclr0  = cclr_e'(tcr_q[0][4:3]);
  assign cclr1  = cclr_e'(tcr_q[1][4:3]);
  assign cclr16 = cclr0;
  assign mode16 = (css0 == CSS_CASCADE);

  assign div[0] = divide_ratio(tccr_q[0][2:0]);
  assign div[1] = divide_ratio(tccr_q[1][2:0]);
  assign run[0] = is_tick && (css0 == CSS_PRESCALER) && (div[0] != '0);
  assign run[1] = is_tick && (css1 == CSS_PRESCALER) && (div[1] != '0);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      nxt[i]  = {1'b0, psc_q[i]} + DivW'(1);
      fire[i] = run[i] && (nxt[i] >= div[i]);
    end
  end

  assign v0  = cnt_q[0] + 8'd1;
  assign ma0 = (v0 == cora_q[0]);
  assign mb0 = (v0 == corb_q[0]);
  assign ov0 = (v0 == 8'd0);
  assign v1  = cnt_q[1] + 8'd1;
  assign ma1 = (v1 == cora_q[1]);
  assign mb1 = (v1 == corb_q[1]);
  assign ov1 = (v1 == 8'd0);
  assign v16  = {cnt_q[0], cnt_q[1]} + 16'd1;
  assign ma16 = (v16 == {cora_q[0], cora_q[1]});
  assign mb16 = (v16 == {corb_q[0], corb_q[1]});
  assign ov16 = (v16 == 16'd0);

  assign inc16 = mode16 && fire[1];
  assign inc0  = !mode16 && fire[0];
  assign inc1  = !mode16 && (fire[1] || ((css1 == CSS_CASCADE) && inc0 && ma0));

  always_comb begin
    cnt_d  = cnt_q;
    cora_d = cora_q;
    corb_d = corb_q;
    tcr_d  = tcr_q;
    tcsr_d = tcsr_q;
    tccr_d = tccr_q;
    psc_d  = psc_q;
    rd_d   = 16'd0;
    pa_d   = 2'b00;
    pb_d   = 2'b00;
    po_d   = 2'b00;
    err_d  = 1'b0;
    rbyte  = 8'd0;
    rmask  = 8'hff;

    for (int i = 0; i < 2; i++) begin
      if (run[i]) begin
        psc_d[i] = fire[i] ? '0 : nxt[i][PscW-1:0];
      end
    end

    if (inc16) begin
      if ((ma16 && (cclr16 == CCLR_MATCH_A)) || (mb16 && (cclr16 == CCLR_MATCH_B))) begin
        cnt_d[0] = 8'd0;
        cnt_d[1] = 8'd0;
      end else begin
        cnt_d[0] = v16[15:8];
        cnt_d[1] = v16[7:0];
      end
      pa_d[0] = ma16 && tcr_q[0][TcrCmiea];
      pb_d[0] = mb16 && tcr_q[0][TcrCmieb];
      po_d[0] = ov16 && tcr_q[0][TcrOvie];
    end
    if (inc0) begin
      if ((ma0 && (cclr0 == CCLR_MATCH_A)) || (mb0 && (cclr0 == CCLR_MATCH_B))) begin
        cnt_d[0] = 8'd0;
      end else begin
        cnt_d[0] = v0;
      end
      pa_d[0] = ma0 && tcr_q[0][TcrCmiea];
      pb_d[0] = mb0 && tcr_q[0][TcrCmieb];
      po_d[0] = ov0 && tcr_q[0][TcrOvie];
    end
    if (inc1) begin
      if ((ma1 && (cclr1 == CCLR_MATCH_A)) || (mb1 && (cclr1 == CCLR_MATCH_B))) begin
        cnt_d[1] = 8'd0;
      end else begin
        cnt_d[1] = v1;
      end
      pa_d[1] = ma1 && tcr_q[1][TcrCmiea];
      pb_d[1] = mb1 && tcr_q[1][TcrCmieb];
      po_d[1] = ov1 && tcr_q[1][TcrOvie];
    end

    if (is_acc && bad) begin
      err_d = 1'b1;
      rd_d  = 16'hffff;
    end else if (op == OP_WRITE) begin
      unique case (rsel)
        REG_TCR:  tcr_d[ch]  = write_data_i[7:0];
        REG_TCSR: tcsr_d[ch] = write_data_i[7:0];
        REG_TCORA: begin
          if (word_access_i) begin
            cora_d[0] = write_data_i[15:8];
            cora_d[1] = write_data_i[7:0];
          end else begin
            cora_d[ch] = write_data_i[7:0];
          end
        end
        REG_TCORB: begin
          if (word_access_i) begin
            corb_d[0] = write_data_i[15:8];
            corb_d[1] = write_data_i[7:0];
          end else begin
            corb_d[ch] = write_data_i[7:0];
          end
        end
        REG_TCNT: begin
          if (word_access_i) begin
            cnt_d[0] = write_data_i[15:8];
            cnt_d[1] = write_data_i[7:0];
          end else begin
            cnt_d[ch] = write_data_i[7:0];
          end
        end
        REG_TCCR: begin
          if (word_access_i) begin
            tccr_d[0] = write_data_i[15:8];
            tccr_d[1] = write_data_i[7:0];
          end else begin
            tccr_d[ch] = write_data_i[7:0];
          end
        end
        default: ;
      endcase
    end else if (op == OP_READ) begin
      unique case (rsel)
        REG_TCR: rd_d = {8'd0, tcr_q[ch] & TcrReadMask};
        REG_TCSR: begin
          if (ch) begin
            rd_d = {8'd0, (tcsr_q[1] & Tcsr1ReadMask) | Tcsr1ReadSet};
          end else begin
            rd_d = {8'd0, tcsr_q[0] & Tcsr0ReadMask};
          end
        end
        REG_TCORA: begin
          rbyte = cora_q[ch];
          rd_d  = word_access_i ? {cora_q[0], cora_q[1]} : {8'd0, rbyte};
        end
        REG_TCORB: begin
          rbyte = corb_q[ch];
          rd_d  = word_access_i ? {corb_q[0], corb_q[1]} : {8'd0, rbyte};
        end
        REG_TCNT: begin
          rbyte = cnt_q[ch];
          rd_d  = word_access_i ? {cnt_q[0], cnt_q[1]} : {8'd0, rbyte};
        end
        REG_TCCR: begin
          rmask = TccrReadMask;
          rbyte = tccr_q[ch] & rmask;
          rd_d  = word_access_i ? {tccr_q[0] & rmask, tccr_q[1] & rmask} : {8'd0, rbyte};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cora_q      <= {CompareReset, CompareReset};
      corb_q      <= {CompareReset, CompareReset};
      tcr_q       <= '0;
      tcsr_q      <= {Tcsr1Reset, 8'h00};
      tccr_q      <= '0;
      psc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q  <= cnt_d;
        cora_q <= cora_d;
        corb_q <= corb_d;
        tcr_q  <= tcr_d;
        tcsr_q <= tcsr_d;
        tccr_q <= tccr_d;
        psc_q  <= psc_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= rd_d;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      po_q  <= po_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rd_q;
  assign match_a_pulse_o  = pa_q;
  assign match_b_pulse_o  = pb_q;
  assign overflow_pulse_o = po_q;
  assign access_error_o   = err_q;

endmodule

>>> dv/tb.sv
// Self-checking testbench for dual_8bit_compare_match_timer_core.
// Drives ticks and register accesses with random gaps and back-pressure, and checks
// every result word against fixed values or a predictor kept here. Uses dcmt_pkg.
module tb;
  import dcmt_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [3:0]  addr;
    logic        wide;
    logic [15:0] data;
  } bus_word_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic [1:0]  cm_a;
    logic [1:0]  cm_b;
    logic [1:0]  ovf;
    logic        err;
  } timer_out_t;

  typedef struct packed {
    bus_word_t  w;
    logic       known;
    timer_out_t res;
  } plan_row_t;

  localparam logic [7:0] RdMaskTcr   = 8'hf8;
  localparam logic [7:0] RdMaskTcsr0 = 8'h3f;
  localparam logic [7:0] RdMaskTcsr1 = 8'h0f;
  localparam logic [7:0] RdSetTcsr1  = 8'h10;
  localparam logic [7:0] RdMaskTccr  = 8'h9f;
  localparam int unsigned NumRandom  = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [3:0]  addr;
  logic        wide;
  logic [15:0] wdata;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] rdata;
  logic [1:0]  cm_a;
  logic [1:0]  cm_b;
  logic [1:0]  ovf;
  logic        err;

  logic [7:0]  tmr [6][2];
  logic [12:0] psc [2];
  logic [1:0]  hit_a;
  logic [1:0]  hit_b;
  logic [1:0]  hit_ov;

  timer_out_t  timer_results_q [$];
  int unsigned bad_results;
  int unsigned words_sent;

  dual_8bit_compare_match_timer_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .addr_i          (addr),
    .word_access_i   (wide),
    .write_data_i    (wdata),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .read_data_o     (rdata),
    .match_a_pulse_o (cm_a),
    .match_b_pulse_o (cm_b),
    .overflow_pulse_o(ovf),
    .access_error_o  (err)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned ticks_per_count(input logic [2:0] cks);
    case (cks)
      3'd0:    return 0;
      3'd1:    return 1;
      3'd2:    return 2;
      3'd3:    return 8;
      3'd4:    return 32;
      3'd5:    return 64;
      3'd6:    return 1024;
      default: return 8192;
    endcase
  endfunction

  function automatic logic prescaler_fire(input int ch);
    int unsigned lim;
    int unsigned n;
    lim = ticks_per_count(tmr[REG_TCCR][ch][2:0]);
    if (tmr[REG_TCCR][ch][4:3] != CSS_PRESCALER || lim == 0) return 1'b0;
    n = psc[ch] + 1;
    if (n >= lim) begin
      psc[ch] = '0;
      return 1'b1;
    end
    psc[ch] = n[12:0];
    return 1'b0;
  endfunction

  function automatic logic bump8(input int ch);
    logic [7:0] t;
    logic [7:0] v;
    logic       ma;
    logic       mb;
    logic       ov;
    t  = tmr[REG_TCR][ch];
    v  = tmr[REG_TCNT][ch] + 8'd1;
    ma = (v == tmr[REG_TCORA][ch]);
    mb = (v == tmr[REG_TCORB][ch]);
    ov = (v == 8'd0);
    if ((ma && t[4:3] == CCLR_MATCH_A) || (mb && t[4:3] == CCLR_MATCH_B)) v = 8'd0;
    tmr[REG_TCNT][ch] = v;
    if (ma && t[6]) hit_a[ch] = 1'b1;
    if (mb && t[7]) hit_b[ch] = 1'b1;
    if (ov && t[5]) hit_ov[ch] = 1'b1;
    return ma;
  endfunction

  function automatic void bump16();
    logic [7:0]  t;
    logic [15:0] v;
    logic        ma;
    logic        mb;
    logic        ov;
    t  = tmr[REG_TCR][0];
    v  = {tmr[REG_TCNT][0], tmr[REG_TCNT][1]} + 16'd1;
    ma = (v == {tmr[REG_TCORA][0], tmr[REG_TCORA][1]});
    mb = (v == {tmr[REG_TCORB][0], tmr[REG_TCORB][1]});
    ov = (v == 16'd0);
    if ((ma && t[4:3] == CCLR_MATCH_A) || (mb && t[4:3] == CCLR_MATCH_B)) v = 16'd0;
    tmr[REG_TCNT][0] = v[15:8];
    tmr[REG_TCNT][1] = v[7:0];
    if (ma && t[6]) hit_a[0] = 1'b1;
    if (mb && t[7]) hit_b[0] = 1'b1;
    if (ov && t[5]) hit_ov[0] = 1'b1;
  endfunction

  function automatic timer_out_t timer_step(input bus_word_t w);
    timer_out_t r;
    logic       ch;
    logic [2:0] rsel;
    logic [7:0] mask;
    logic       ma0;
    logic       fire1;
    r      = '0;
    hit_a  = '0;
    hit_b  = '0;
    hit_ov = '0;
    ch     = w.addr[0];
    rsel   = w.addr[3:1];
    if (w.op == OP_TICK) begin
      if (tmr[REG_TCCR][0][4:3] == CSS_CASCADE) begin
        if (prescaler_fire(1)) bump16();
      end else begin
        ma0 = 1'b0;
        if (prescaler_fire(0)) ma0 = bump8(0);
        fire1 = prescaler_fire(1);
        if (tmr[REG_TCCR][1][4:3] == CSS_CASCADE && ma0) fire1 = 1'b1;
        if (fire1) void'(bump8(1));
      end
      r.cm_a = hit_a;
      r.cm_b = hit_b;
      r.ovf  = hit_ov;
    end else if (w.op == OP_READ || w.op == OP_WRITE) begin
      if ((w.wide && (ch || rsel == REG_TCR || rsel == REG_TCSR)) || rsel > REG_TCCR) begin
        r.err   = 1'b1;
        r.rdata = 16'hffff;
      end else if (w.op == OP_WRITE) begin
        if (w.wide) begin
          tmr[rsel][0] = w.data[15:8];
          tmr[rsel][1] = w.data[7:0];
        end else begin
          tmr[rsel][ch] = w.data[7:0];
        end
      end else begin
        mask = 8'hff;
        if (rsel == REG_TCR) mask = RdMaskTcr;
        if (rsel == REG_TCCR) mask = RdMaskTccr;
        if (rsel == REG_TCSR) begin
          if (ch) r.rdata = {8'h00, (tmr[REG_TCSR][1] & RdMaskTcsr1) | RdSetTcsr1};
          else r.rdata = {8'h00, tmr[REG_TCSR][0] & RdMaskTcsr0};
        end else if (w.wide) begin
          r.rdata = {tmr[rsel][0] & mask, tmr[rsel][1] & mask};
        end else begin
          r.rdata = {8'h00, tmr[rsel][ch] & mask};
        end
      end
    end
    return r;
  endfunction

  function automatic plan_row_t mk(input op_e o, input logic [3:0] a, input logic wd,
                                   input logic [15:0] d, input logic known,
                                   input logic [15:0] rd, input logic e);
    plan_row_t p;
    p           = '0;
    p.w.op      = o;
    p.w.addr    = a;
    p.w.wide    = wd;
    p.w.data    = d;
    p.known     = known;
    p.res.rdata = rd;
    p.res.err   = e;
    return p;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [2:0] rsel);
    logic [7:0] b;
    logic [1:0] css;
    logic [2:0] cks;
    int unsigned r;
    case (rsel)
      REG_TCORA, REG_TCORB: begin
        b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      end
      REG_TCNT: begin
        b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(248, 255));
      end
      REG_TCCR: begin
        r = $urandom_range(0, 9);
        if (r < 6) css = CSS_PRESCALER;
        else if (r < 8) css = CSS_CASCADE;
        else css = 2'($urandom);
        cks = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 3)) : 3'($urandom);
        b = {1'($urandom), 2'($urandom), css, cks};
      end
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic bus_word_t rand_word();
    bus_word_t   w;
    int unsigned r;
    logic [2:0]  rsel;
    logic [7:0]  hi;
    w.addr = 4'($urandom);
    w.wide = 1'($urandom);
    w.data = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      w.op = OP_TICK;
    end else if (r < 58) begin
      w.op = OP_IDLE;
    end else if (r < 72) begin
      w.op   = OP_READ;
      w.wide = ($urandom_range(0, 3) == 0);
    end else begin
      w.op = OP_WRITE;
      r    = $urandom_range(0, 11);
      if (r < 8) rsel = r[2:0];
      else if (r < 10) rsel = REG_TCCR;
      else rsel = REG_TCORA;
      w.addr = {rsel, 1'($urandom)};
      w.wide = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) != 0) begin
        hi = pick_byte(rsel);
        if (w.wide && rsel != REG_TCCR && $urandom_range(0, 1) == 0) hi = 8'h00;
        w.data = {hi, pick_byte(rsel)};
      end
    end
    return w;
  endfunction

  task automatic drive(input bus_word_t w, input logic known, input timer_out_t typed);
    int unsigned gap;
    timer_out_t  pred;
    gap = ((words_sent / 100) % 4 == 3) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= w.op;
    addr     <= w.addr;
    wide     <= w.wide;
    wdata    <= w.data;
    do @(posedge clk); while (!in_ready);
    pred = timer_step(w);
    timer_results_q.push_back(known ? typed : pred);
    words_sent++;
    @(negedge clk);
  endtask

  initial begin : result_side
    int unsigned stall;
    int unsigned got;
    timer_out_t  seen;
    timer_out_t  want;
    out_ready = 1'b0;
    got       = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (got == 300 || got == 800) stall = 64;
      else if ((got / 100) % 4 == 1) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen = '{rdata: rdata, cm_a: cm_a, cm_b: cm_b, ovf: ovf, err: err};
      if (timer_results_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("Unexpected result word: rd=%h", seen.rdata);
      end else begin
        want = timer_results_q.pop_front();
        if (seen.rdata != want.rdata || seen.cm_a != want.cm_a || seen.cm_b != want.cm_b ||
            seen.ovf != want.ovf || seen.err != want.err) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("Mismatch on word %0d: expected rd=%h a=%b b=%b ov=%b err=%b", got,
                     want.rdata, want.cm_a, want.cm_b, want.ovf, want.err);
            $display("  actual rd=%h a=%b b=%b ov=%b err=%b",
                     seen.rdata, seen.cm_a, seen.cm_b, seen.ovf, seen.err);
          end
        end
      end
      got++;
      @(negedge clk);
    end
  end

  initial begin : bus_side
    plan_row_t plan [$];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    op          = OP_TICK;
    addr        = '0;
    wide        = 1'b0;
    wdata       = '0;
    bad_results = 0;
    words_sent  = 0;
    for (int i = 0; i < 6; i++) begin
      tmr[i][0] = 8'h00;
      tmr[i][1] = 8'h00;
    end
    tmr[REG_TCORA][0] = 8'hff;
    tmr[REG_TCORA][1] = 8'hff;
    tmr[REG_TCORB][0] = 8'hff;
    tmr[REG_TCORB][1] = 8'hff;
    tmr[REG_TCSR][1]  = 8'h10;
    psc[0]            = '0;
    psc[1]            = '0;

    plan.push_back(mk(OP_READ,  4'd0,  1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0));
    plan.push_back(mk(OP_READ,  4'd3,  1'b0, 16'h0000, 1'b1, 16'h0010, 1'b0));
    plan.push_back(mk(OP_READ,  4'd4,  1'b1, 16'h0000, 1'b1, 16'hffff, 1'b0));
    plan.push_back(mk(OP_READ,  4'd10, 1'b1, 16'h0000, 1'b1, 16'h0000, 1'b0));
    plan.push_back(mk(OP_READ,  4'd0,  1'b1, 16'h0000, 1'b1, 16'hffff, 1'b1));
    plan.push_back(mk(OP_WRITE, 4'd2,  1'b1, 16'hffff, 1'b1, 16'hffff, 1'b1));
    plan.push_back(mk(OP_WRITE, 4'd9,  1'b1, 16'habcd, 1'b1, 16'hffff, 1'b1));
    plan.push_back(mk(OP_READ,  4'd12, 1'b0, 16'h0000, 1'b1, 16'hffff, 1'b1));
    plan.push_back(mk(OP_WRITE, 4'd14, 1'b0, 16'h5a5a, 1'b1, 16'hffff, 1'b1));
    plan.push_back(mk(OP_IDLE,  4'd15, 1'b1, 16'hffff, 1'b1, 16'h0000, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd0,  1'b0, 16'hffff, 1'b1, 16'h0000, 1'b0));
    plan.push_back(mk(OP_READ,  4'd0,  1'b0, 16'h0000, 1'b1, 16'h00f8, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd2,  1'b0, 16'h00ff, 1'b1, 16'h0000, 1'b0));
    plan.push_back(mk(OP_READ,  4'd2,  1'b0, 16'h0000, 1'b1, 16'h003f, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd3,  1'b0, 16'h00ff, 1'b1, 16'h0000, 1'b0));
    plan.push_back(mk(OP_READ,  4'd3,  1'b0, 16'h0000, 1'b1, 16'h001f, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd10, 1'b1, 16'hffff, 1'b1, 16'h0000, 1'b0));
    plan.push_back(mk(OP_READ,  4'd10, 1'b1, 16'h0000, 1'b1, 16'h9f9f, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd4,  1'b1, 16'h0203, 1'b0, 16'h0000, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd0,  1'b0, 16'h0068, 1'b0, 16'h0000, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd1,  1'b0, 16'h00e0, 1'b0, 16'h0000, 1'b0));
    plan.push_back(mk(OP_WRITE, 4'd10, 1'b1, 16'h0919, 1'b0, 16'h0000, 1'b0));
    for (int i = 0; i < 4; i++) begin
      plan.push_back(mk(OP_TICK, 4'd0, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) drive(plan[i].w, plan[i].known, plan[i].res);
    repeat (NumRandom) drive(rand_word(), 1'b0, '0);
    in_valid <= 1'b0;
    while (timer_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
